// File: rtl/tgcw_pkg.sv
// Shared constants, types and helpers for the trilinear grid corner weight core.
// Holds register codes, field widths and fixed-point constants.
// No dependencies.
package tgcw_pkg;

  localparam int MAX_DIM     = 1024;
  localparam int FRAC_BITS   = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int NUM_AXES    = 3;
  localparam int NUM_CORNERS = 8;

  localparam int COORD_W   = 32;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int DIM_W     = 11;
  localparam int CELL_W    = $clog2(MAX_DIM);
  localparam int AREA_W    = 2 * DIM_W;
  localparam int IDX_W     = 31;
  localparam int WGT_W     = WEIGHT_BITS + 1;
  localparam int FR_W      = FRAC_BITS + 1;
  localparam int WPROD_W   = 2 * FR_W;
  localparam int CNT_W     = $clog2(NUM_CORNERS);
  localparam int CFG_IDX_W = 3;

  // Fixed-point constants of the weight path.
  localparam int W_SH = 2 * FRAC_BITS - WEIGHT_BITS;
  localparam logic [FR_W-1:0]    ONE    = FR_W'(1) << FRAC_BITS;
  localparam logic [WPROD_W-1:0] ROUND1 = WPROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [WPROD_W-1:0] ROUND2 = WPROD_W'(1) << (W_SH - 1);
  localparam logic [CNT_W-1:0]   LAST_CORNER = CNT_W'(NUM_CORNERS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_ORIGIN_Z    = 3'd2,
    REG_INV_SPACING = 3'd3,
    REG_DIM_X       = 3'd4,
    REG_DIM_Y       = 3'd5,
    REG_DIM_Z       = 3'd6
  } cfg_reg_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [DIM_W-1:0]          dim_t;
  typedef logic [CELL_W-1:0]         cell_t;
  typedef logic [FRAC_BITS-1:0]      frac_t;

  // Dimensions above the supported maximum are treated as the maximum.
  function automatic dim_t clamp_dim(input dim_t d);
    dim_t res;
    if (d > DIM_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = d;
    end
    return res;
  endfunction

endpackage

// File: rtl/trilinear_grid_corner_weights_core.sv
// Trilinear grid corner weight core: maps a Q16.16 point to eight grid corners.
// Front pipeline splits each axis into cell and fraction; a corner sequencer
// and a two-stage weight pipeline emit one corner per cycle. Uses tgcw_pkg.

// Usage: a point is taken on a clock edge where start is high and busy is low,
// and yields eight results on consecutive cycles, marked by out_valid, corner 0
// first and out_last on corner 7. The result port delivers one corner per cycle,
// so each point holds the port for its eight corners; when the sequencer is free,
// a point passes the four front stages, the sequencer and two weight stages.
// Points may be offered back to back: four front stages buffer them while the
// sequencer is still emitting an earlier point, and busy rises only when all of
// them are full. Results cannot be held off. Configuration writes are always
// ready and must only be made while no point is in flight.
module trilinear_grid_corner_weights_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [tgcw_pkg::COORD_W-1:0]  in_pos_x,
  input  logic signed [tgcw_pkg::COORD_W-1:0]  in_pos_y,
  input  logic signed [tgcw_pkg::COORD_W-1:0]  in_pos_z,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tgcw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tgcw_pkg::COORD_W-1:0]         cfg_data,
  output logic                                 out_valid,
  output logic [tgcw_pkg::CNT_W-1:0]           out_corner,
  output logic signed [tgcw_pkg::IDX_W-1:0]    out_corner_index,
  output logic [tgcw_pkg::WGT_W-1:0]           out_corner_weight,
  output logic                                 out_inside_res,
  output logic                                 out_last
);

  // Configuration registers.
  tgcw_pkg::coord_t                origin_r [tgcw_pkg::NUM_AXES];
  logic [tgcw_pkg::COORD_W-1:0]    spacing_recip_r;
  tgcw_pkg::dim_t                  dim_r [tgcw_pkg::NUM_AXES];
  tgcw_pkg::dim_t                  dim_c [tgcw_pkg::NUM_AXES];
  logic [tgcw_pkg::AREA_W-1:0]     area_yz_r;

  // Front pipeline.
  logic                            en1, en2, en3, en4;
  logic                            v1_r, v2_r, v3_r, v4_r;
  tgcw_pkg::coord_t                pos_in [tgcw_pkg::NUM_AXES];
  logic signed [tgcw_pkg::DIFF_W-1:0] diff1_r [tgcw_pkg::NUM_AXES];
  logic [tgcw_pkg::PROD_W-1:0]     prod2_r [tgcw_pkg::NUM_AXES];
  logic                            neg2_r [tgcw_pkg::NUM_AXES];
  tgcw_pkg::cell_t                 cell3_r [tgcw_pkg::NUM_AXES];
  tgcw_pkg::frac_t                 frac3_r [tgcw_pkg::NUM_AXES];
  logic                            inside3_r;
  logic [tgcw_pkg::NUM_AXES-1:0]   axis_ok;
  logic [tgcw_pkg::IDX_W-1:0]      rowx4_r;
  logic [tgcw_pkg::IDX_W-1:0]      rowy4_r;
  tgcw_pkg::cell_t                 cellz4_r;
  tgcw_pkg::frac_t                 frac4_r [tgcw_pkg::NUM_AXES];
  logic                            inside4_r;

  // Corner sequencer.
  logic                            sq_load;
  logic                            sq_v_r;
  logic [tgcw_pkg::CNT_W-1:0]      sq_cnt_r;
  logic [tgcw_pkg::IDX_W-1:0]      sq_base_r;
  tgcw_pkg::frac_t                 sq_frac_r [tgcw_pkg::NUM_AXES];
  logic                            sq_inside_r;

  // Weight pipeline.
  logic [tgcw_pkg::FR_W-1:0]       fac [tgcw_pkg::NUM_AXES];
  logic [tgcw_pkg::WPROD_W-1:0]    ab_full;
  logic [tgcw_pkg::WPROD_W-1:0]    w_full;
  logic [tgcw_pkg::IDX_W-1:0]      idx_nxt;
  logic                            e1_v_r;
  logic [tgcw_pkg::CNT_W-1:0]      e1_corner_r;
  logic [tgcw_pkg::FR_W-1:0]       e1_ab_r;
  logic [tgcw_pkg::FR_W-1:0]       e1_c_r;
  logic [tgcw_pkg::IDX_W-1:0]      e1_idx_r;
  logic                            e1_inside_r;

  logic                            out_valid_r;
  logic [tgcw_pkg::CNT_W-1:0]      out_corner_r;
  logic [tgcw_pkg::IDX_W-1:0]      out_idx_r;
  logic [tgcw_pkg::WGT_W-1:0]      out_weight_r;
  logic                            out_inside_r;
  logic                            out_last_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r[0]     <= -tgcw_pkg::COORD_W'(32768);
      origin_r[1]     <= -tgcw_pkg::COORD_W'(32768);
      origin_r[2]     <= -tgcw_pkg::COORD_W'(32768);
      spacing_recip_r <= tgcw_pkg::COORD_W'(65536);
      dim_r[0]        <= '0;
      dim_r[1]        <= '0;
      dim_r[2]        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (tgcw_pkg::cfg_reg_t'(cfg_index))
        tgcw_pkg::REG_ORIGIN_X:    origin_r[0]     <= cfg_data;
        tgcw_pkg::REG_ORIGIN_Y:    origin_r[1]     <= cfg_data;
        tgcw_pkg::REG_ORIGIN_Z:    origin_r[2]     <= cfg_data;
        tgcw_pkg::REG_INV_SPACING: spacing_recip_r <= cfg_data;
        tgcw_pkg::REG_DIM_X:       dim_r[0]        <= cfg_data[tgcw_pkg::DIM_W-1:0];
        tgcw_pkg::REG_DIM_Y:       dim_r[1]        <= cfg_data[tgcw_pkg::DIM_W-1:0];
        tgcw_pkg::REG_DIM_Z:       dim_r[2]        <= cfg_data[tgcw_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < tgcw_pkg::NUM_AXES; a++) begin
      dim_c[a] = tgcw_pkg::clamp_dim(dim_r[a]);
    end
  end

  // The y-z plane size only changes with configuration, so it is simply
  // registered every cycle ahead of its use in the fourth stage.
  always_ff @(posedge clk) begin
    area_yz_r <= tgcw_pkg::AREA_W'(dim_c[1]) * tgcw_pkg::AREA_W'(dim_c[2]);
  end

  // Each stage loads when it is empty or its contents move on.
  assign sq_load = v4_r && (!sq_v_r || (sq_cnt_r == tgcw_pkg::LAST_CORNER));
  assign en4     = !v4_r || sq_load;
  assign en3     = !v3_r || en4;
  assign en2     = !v2_r || en3;
  assign en1     = !v1_r || en2;
  assign busy    = !en1;

  assign pos_in[0] = in_pos_x;
  assign pos_in[1] = in_pos_y;
  assign pos_in[2] = in_pos_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= start;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (en4) begin
        v4_r <= v3_r;
      end
    end
  end

  // Stage 1: offset from the grid origin.
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int a = 0; a < tgcw_pkg::NUM_AXES; a++) begin
        diff1_r[a] <= tgcw_pkg::DIFF_W'(pos_in[a]) - tgcw_pkg::DIFF_W'(origin_r[a]);
      end
    end
  end

  // Stage 2: exact Q32.32 scaled offset; a negative offset multiplies as zero.
  always_ff @(posedge clk) begin
    if (en2) begin
      for (int a = 0; a < tgcw_pkg::NUM_AXES; a++) begin
        prod2_r[a] <= (diff1_r[a][tgcw_pkg::DIFF_W-1] ? tgcw_pkg::PROD_W'(0) :
                       tgcw_pkg::PROD_W'(diff1_r[a][tgcw_pkg::COORD_W-1:0])) *
                      tgcw_pkg::PROD_W'(spacing_recip_r);
        neg2_r[a]  <= diff1_r[a][tgcw_pkg::DIFF_W-1];
      end
    end
  end

  // Stage 3: cell, fraction and the range test per axis.
  always_comb begin
    for (int a = 0; a < tgcw_pkg::NUM_AXES; a++) begin
      axis_ok[a] = !(neg2_r[a] && (spacing_recip_r != '0)) &&
                   (dim_c[a] >= tgcw_pkg::DIM_W'(2)) &&
                   (prod2_r[a][tgcw_pkg::PROD_W-1 -: tgcw_pkg::COORD_W] <
                    tgcw_pkg::COORD_W'(dim_c[a]) - tgcw_pkg::COORD_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int a = 0; a < tgcw_pkg::NUM_AXES; a++) begin
        cell3_r[a] <= prod2_r[a][tgcw_pkg::COORD_W +: tgcw_pkg::CELL_W];
        frac3_r[a] <= prod2_r[a][tgcw_pkg::COORD_W-1 -: tgcw_pkg::FRAC_BITS];
      end
      inside3_r <= &axis_ok;
    end
  end

  // Stage 4: row-major partial products of the base corner index.
  always_ff @(posedge clk) begin
    if (en4) begin
      rowx4_r   <= tgcw_pkg::IDX_W'(cell3_r[0]) * tgcw_pkg::IDX_W'(area_yz_r);
      rowy4_r   <= tgcw_pkg::IDX_W'(tgcw_pkg::IDX_W'(cell3_r[1]) * tgcw_pkg::IDX_W'(dim_c[2]));
      cellz4_r  <= cell3_r[2];
      frac4_r   <= frac3_r;
      inside4_r <= inside3_r;
    end
  end

  // Corner sequencer: holds one point and steps through its eight corners.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r   <= 1'b0;
      sq_cnt_r <= '0;
    end else if (sq_load) begin
      sq_v_r   <= 1'b1;
      sq_cnt_r <= '0;
    end else if (sq_v_r) begin
      if (sq_cnt_r == tgcw_pkg::LAST_CORNER) begin
        sq_v_r <= 1'b0;
      end
      sq_cnt_r <= sq_cnt_r + tgcw_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (sq_load) begin
      sq_base_r   <= rowx4_r + rowy4_r + tgcw_pkg::IDX_W'(cellz4_r);
      sq_frac_r   <= frac4_r;
      sq_inside_r <= inside4_r;
    end
  end

  // Weight stage 1: per-axis factors and the x-y product.
  // Axis x follows the top corner bit, axis z the bottom one.
  always_comb begin
    for (int a = 0; a < tgcw_pkg::NUM_AXES; a++) begin
      if (sq_cnt_r[tgcw_pkg::NUM_AXES-1-a]) begin
        fac[a] = tgcw_pkg::FR_W'(sq_frac_r[a]);
      end else begin
        fac[a] = tgcw_pkg::ONE - tgcw_pkg::FR_W'(sq_frac_r[a]);
      end
    end
    ab_full = tgcw_pkg::WPROD_W'(fac[0]) * tgcw_pkg::WPROD_W'(fac[1]) + tgcw_pkg::ROUND1;
    idx_nxt = sq_base_r +
              (sq_cnt_r[2] ? tgcw_pkg::IDX_W'(area_yz_r) : '0) +
              (sq_cnt_r[1] ? tgcw_pkg::IDX_W'(dim_c[2]) : '0) +
              tgcw_pkg::IDX_W'(sq_cnt_r[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
    end else begin
      e1_v_r <= sq_v_r;
    end
  end

  always_ff @(posedge clk) begin
    e1_corner_r <= sq_cnt_r;
    e1_ab_r     <= ab_full[tgcw_pkg::FRAC_BITS +: tgcw_pkg::FR_W];
    e1_c_r      <= fac[2];
    e1_idx_r    <= idx_nxt;
    e1_inside_r <= sq_inside_r;
  end

  // Weight stage 2: third factor, rounding and the outside substitution.
  assign w_full = tgcw_pkg::WPROD_W'(e1_ab_r) * tgcw_pkg::WPROD_W'(e1_c_r) + tgcw_pkg::ROUND2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= e1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_corner_r <= e1_corner_r;
    out_inside_r <= e1_inside_r;
    out_last_r   <= (e1_corner_r == tgcw_pkg::LAST_CORNER);
    if (e1_inside_r) begin
      out_idx_r    <= e1_idx_r;
      out_weight_r <= w_full[tgcw_pkg::W_SH +: tgcw_pkg::WGT_W];
    end else begin
      out_idx_r    <= '1;
      out_weight_r <= '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_corner        = out_corner_r;
  assign out_corner_index  = out_idx_r;
  assign out_corner_weight = out_weight_r;
  assign out_inside_res    = out_inside_r;
  assign out_last          = out_last_r;

  // A run of eight corners is never broken and counts up by one.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && (out_corner == $past(out_corner) + 3'd1))
    else $error("corner run broken or out of order");

  // A run only starts after the previous run has finished.
  a_run_starts_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_corner == '0) |-> !$past(out_valid) || $past(out_last))
    else $error("corner run started inside another run");

  // All corners of one point agree on whether it is inside.
  a_inside_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_corner != '0) |-> $past(out_valid) &&
      (out_inside_res == $past(out_inside_res)))
    else $error("inside flag changed within a run");

  // After a load, which needs a point in the fourth stage, the sequencer holds it at corner 0.
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    sq_load |=> sq_v_r && (sq_cnt_r == '0))
    else $error("sequencer load lost");

endmodule
